/* design/pts_pkg.sv */
// Shared types and constants for the periodic task scheduler.
`timescale 1ns / 1ps

package pts_pkg;

	localparam int TICK_W   = 32;
	localparam int MAX_OUT  = 8;
	localparam int FIRE_W   = 4;
	localparam int TIDX_W   = 3;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_RUN  = 2'd1,
		CMD_ADD  = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_e;

	typedef struct packed {
		logic [1:0]        command;
		logic [TICK_W-1:0] period;
	} req_t;

	typedef struct packed {
		logic [TIDX_W-1:0] task_index;
		logic              fired;
		logic              add_accepted;
		logic [TICK_W-1:0] tick_count;
		logic              last;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DONE
	} state_e;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic exec_single;
		logic scan_start;
		logic scan_step;
		logic finish;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic is_run;
		logic scan_end;
		logic due_stall;
		logic out_free;
	} sts_t;

endpackage

/* design/pts_ctrl.sv */
// Sequencing state machine of the periodic task scheduler.
`timescale 1ns / 1ps

module pts_ctrl import pts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output ctl_t ctl
);

	state_e state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_run) begin
					ctl.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end else if (sts.out_free) begin
					ctl.exec_single = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (sts.scan_end) begin
					state_d = ST_DONE;
				end else if (!sts.due_stall) begin
					ctl.scan_step = 1'b1;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* design/pts_datapath.sv */
// Tick counter, task table, slot scanner and result register.
`timescale 1ns / 1ps

module pts_datapath import pts_pkg::*; #(
	parameter int TASK_SLOTS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  ctl_t ctl,
	output sts_t sts,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CW = $clog2(TASK_SLOTS + 1);

	logic [1:0]        cmd_q;
	logic [TICK_W-1:0] per_q;
	logic [TICK_W-1:0] tick_q;
	logic [TICK_W-1:0] now_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [FIRE_W-1:0] fire_cnt_q;
	logic              pend_valid_q;
	logic [TIDX_W-1:0] pend_idx_q;
	logic [TICK_W-1:0] period_q [TASK_SLOTS];
	logic [TICK_W-1:0] next_q   [TASK_SLOTS];
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [TICK_W-1:0] diff;
	logic              due;
	logic              out_free;
	logic              add_ok;
	logic [TICK_W-1:0] tick_d;
	logic              wr_en;
	rsp_t              wr_data;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign diff     = now_q - next_q[idx_q[IW-1:0]];
	assign due      = !diff[TICK_W-1];
	assign add_ok   = (cmd_q == CMD_ADD) && (count_q < CW'(TASK_SLOTS));
	assign tick_d   = (cmd_q == CMD_TICK) ? tick_q + 1'b1 : tick_q;

	assign sts.is_run    = (cmd_q == CMD_RUN);
	assign sts.scan_end  = (idx_q >= count_q) || (fire_cnt_q == FIRE_W'(MAX_OUT));
	assign sts.due_stall = due && pend_valid_q && !out_free;
	assign sts.out_free  = out_free;

	// Result write: a due slot pushes out the previously found one (not last).
	always_comb begin
		wr_en   = 1'b0;
		wr_data = '0;
		wr_data.tick_count = tick_q;
		if (ctl.exec_single) begin
			wr_en                = 1'b1;
			wr_data.tick_count   = tick_d;
			wr_data.add_accepted = add_ok;
			wr_data.last         = 1'b1;
		end else if (ctl.scan_step && due && pend_valid_q) begin
			wr_en              = 1'b1;
			wr_data.task_index = pend_idx_q;
			wr_data.fired      = 1'b1;
		end else if (ctl.finish) begin
			wr_en              = 1'b1;
			wr_data.task_index = pend_valid_q ? pend_idx_q : '0;
			wr_data.fired      = pend_valid_q;
			wr_data.last       = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q       <= '0;
			count_q      <= '0;
			rsp_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			fire_cnt_q   <= '0;
			idx_q        <= '0;
		end else begin
			if (wr_en) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (ctl.exec_single) begin
				tick_q <= tick_d;
				if (add_ok) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (ctl.scan_start) begin
				idx_q        <= '0;
				fire_cnt_q   <= '0;
				pend_valid_q <= 1'b0;
			end else if (ctl.scan_step) begin
				idx_q <= idx_q + 1'b1;
				if (due) begin
					fire_cnt_q   <= fire_cnt_q + 1'b1;
					pend_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= req.command;
			per_q <= req.period;
		end
		if (ctl.scan_start) begin
			now_q <= tick_q;
		end
		if (wr_en) begin
			rsp_q <= wr_data;
		end
		if (ctl.scan_step && due) begin
			pend_idx_q <= TIDX_W'(idx_q);
		end
	end

	// Task table: written by add at the fill slot, by the scan at the current slot.
	always_ff @(posedge clk) begin
		if (ctl.exec_single && add_ok) begin
			period_q[count_q[IW-1:0]] <= per_q;
			next_q[count_q[IW-1:0]]   <= per_q;
		end else if (ctl.scan_step && due) begin
			next_q[idx_q[IW-1:0]] <= next_q[idx_q[IW-1:0]] + period_q[idx_q[IW-1:0]];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* design/periodic_task_scheduler_unit.sv */
// Top level of the cooperative periodic task scheduler.
`timescale 1ns / 1ps
// Flow: tick, add and unused commands put their one result in the output register
//   from EXEC once the output is free; run opens a scan and ends in DONE.
// Throughput: one request at a time; a new request is taken only back in IDLE, after
//   the one-slot-per-cycle scan (held while a due slot waits on a busy output) and output stalls.
// Reset (arst_n low): tick counter, task count and output valid clear at once;
//   the period and next-due table is not cleared, it is only read once written.

module periodic_task_scheduler_unit import pts_pkg::*; #(
	parameter int TASK_SLOTS = 8
) (
	input  logic clk,
	input  logic arst_n,
	// command request channel
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	// result channel
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	ctl_t ctl;
	sts_t sts;

	// Controller: IDLE takes a request, EXEC runs tick/add or opens a scan, SCAN walks
	// one slot per cycle unless a due slot waits on a busy output, DONE writes the final (last) result.
	pts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Datapath: counter, task table, wrap-safe due test, held pending result
	// so that the last flag lands on the final fired slot.
	pts_datapath #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctl       (ctl),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
